FILE: hdl/dfiir_pkg.sv
// ----------------------------------------------------------------------------
// dfiir_pkg
// Shared types and constants of the direct-form I filter: gain format,
// datapath issue control and the microcode program of the sequencer.
// ----------------------------------------------------------------------------
package dfiir_pkg;

  // Gain format: signed Q2.16
  localparam int GAIN_W    = 18;
  localparam int FRAC_BITS = 16;
  localparam logic signed [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);

  // Input word kinds (carried on tuser)
  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // Jump conditions of the sequencer
  typedef enum logic [2:0] {
    JC_NEVER    = 3'd0,
    JC_ALWAYS   = 3'd1,
    JC_NO_START = 3'd2,
    JC_FF_MORE  = 3'd3,
    JC_FB_MORE  = 3'd4,
    JC_NO_FB    = 3'd5,
    JC_OUT_BUSY = 3'd6
  } jcond_t;

  localparam int PC_W = 3;

  // Step addresses
  localparam logic [PC_W-1:0] STEP_IDLE   = 3'd0;
  localparam logic [PC_W-1:0] STEP_FF     = 3'd1;
  localparam logic [PC_W-1:0] STEP_FB_CHK = 3'd2;
  localparam logic [PC_W-1:0] STEP_FB     = 3'd3;
  localparam logic [PC_W-1:0] STEP_DRAIN0 = 3'd4;
  localparam logic [PC_W-1:0] STEP_DRAIN1 = 3'd5;
  localparam logic [PC_W-1:0] STEP_FIN    = 3'd6;
  localparam logic [PC_W-1:0] STEP_RET    = 3'd7;

  // One control word per step
  typedef struct packed {
    logic            take;      // input port open
    logic            ff_issue;  // issue one feed-forward tap
    logic            fb_issue;  // issue one feedback tap
    logic            fin;       // round, saturate, load output word
    jcond_t          cond;      // jump when true ...
    logic [PC_W-1:0] target;    // ... to here, else fall through
  } ctl_word_t;

  // Issue control toward the multiply-accumulate unit
  typedef struct packed {
    logic vld;
    logic sub;
  } mac_ctl_t;

  localparam int PROG_LEN = 8;

  localparam ctl_word_t UCODE [PROG_LEN] = '{
    '{1'b1, 1'b0, 1'b0, 1'b0, JC_NO_START, STEP_IDLE},   // wait for a word
    '{1'b0, 1'b1, 1'b0, 1'b0, JC_FF_MORE,  STEP_FF},     // feed-forward taps
    '{1'b0, 1'b0, 1'b0, 1'b0, JC_NO_FB,    STEP_DRAIN0}, // skip empty feedback
    '{1'b0, 1'b0, 1'b1, 1'b0, JC_FB_MORE,  STEP_FB},     // feedback taps
    '{1'b0, 1'b0, 1'b0, 1'b0, JC_NEVER,    STEP_IDLE},   // pipeline drain
    '{1'b0, 1'b0, 1'b0, 1'b0, JC_NEVER,    STEP_IDLE},   // pipeline drain
    '{1'b0, 1'b0, 1'b0, 1'b1, JC_OUT_BUSY, STEP_FIN},    // result out
    '{1'b0, 1'b0, 1'b0, 1'b0, JC_ALWAYS,   STEP_IDLE}    // back to idle
  };

endpackage

FILE: hdl/direct_form_iir_filter_core.sv
// ----------------------------------------------------------------------------
// direct_form_iir_filter_core
// Direct-form I filter with a microcoded sequencer over one shared
// multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: tdata carries the signed sample, tuser the kind
//   (filter one sample, or clear both histories). A clear gives no result.
//   Output stream m_*: tdata carries the filtered sample and the clip flag.
//   Gains are written through cfg_we/cfg_index/cfg_data while the block is
//   idle; feed-forward gains come first, then feedback gains.
// Timing:
//   The sequencer walks the taps one per cycle through the shared multiplier,
//   feed-forward taps first, then feedback taps; after the drain steps the
//   result word is loaded in the finish step. A clear word is taken in the
//   idle step, which the sequencer does not leave for it.
// Reset:
//   Histories read as zero, ff gain 0 is 1.0 and all other gains are zero.
// Stall:
//   A finished word waits in the output register; the next word is accepted
//   meanwhile and its result waits in the finish step until the register
//   frees up.
// ----------------------------------------------------------------------------
module direct_form_iir_filter_core #(
  parameter int FF_TAPS      = 5,
  parameter int FB_TAPS      = 3,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  // slave side: tdata = {pad, sample}; tuser = op
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_tdata,
  input  logic                                  s_tuser,
  // master side: tdata = {pad, saturated, filtered}
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [((SAMPLE_WIDTH+8)/8)*8-1:0]     m_tdata,
  // configuration write port
  input  logic                                  cfg_we,
  input  logic [$clog2(FF_TAPS+FB_TAPS+1)-1:0]  cfg_index,
  input  logic [dfiir_pkg::GAIN_W-1:0]          cfg_data
);
  import dfiir_pkg::*;

  localparam int OUT_W    = ((SAMPLE_WIDTH + 8) / 8) * 8;
  localparam int CFG_IW   = $clog2(FF_TAPS + FB_TAPS + 1);
  localparam bit HAS_FB   = (FB_TAPS > 0);
  localparam int FB_DEPTH = HAS_FB ? FB_TAPS : 1;
  localparam int FF_AW    = (FF_TAPS > 1) ? $clog2(FF_TAPS) : 1;
  localparam int FB_AW    = (FB_DEPTH > 1) ? $clog2(FB_DEPTH) : 1;
  localparam int MAX_T    = (FF_TAPS > FB_DEPTH) ? FF_TAPS : FB_DEPTH;
  localparam int TAP_W    = $clog2(MAX_T + 1);
  localparam int ACC_W    = SAMPLE_WIDTH + GAIN_W + $clog2(FF_TAPS + FB_TAPS + 1) + 1;

  // sequencer
  logic [PC_W-1:0] pc, pc_next;
  ctl_word_t       ctl;
  logic            jump;
  logic [TAP_W-1:0] tap;
  logic            ff_last, fb_last;
  logic            accept, push, clr, out_busy, fin_load;

  // histories and gains
  logic signed [SAMPLE_WIDTH-1:0] x_mem [FF_TAPS];
  logic [FF_TAPS-1:0]             x_valid;
  logic [FF_AW-1:0]               xh, xh_next, xrp;
  logic signed [SAMPLE_WIDTH-1:0] y_mem [FB_DEPTH];
  logic [FB_DEPTH-1:0]            y_valid;
  logic [FB_AW-1:0]               yh, yh_next, yrp;
  logic signed [GAIN_W-1:0]       ff_mem [FF_TAPS];
  logic [FF_TAPS-1:0]             ff_gv;
  logic signed [GAIN_W-1:0]       fb_mem [FB_DEPTH];
  logic [FB_DEPTH-1:0]            fb_gv;
  logic [FF_AW-1:0]               ff_gaddr;
  logic [FB_AW-1:0]               fb_gaddr;
  logic [CFG_IW-1:0]              fb_cidx;

  // read stage
  logic signed [SAMPLE_WIDTH-1:0] x_rd, y_rd;
  logic signed [GAIN_W-1:0]       ffg_rd, fbg_rd;
  mac_ctl_t                       rd_ctl;
  logic signed [SAMPLE_WIDTH-1:0] mac_smp;
  logic signed [GAIN_W-1:0]       mac_gain;
  logic signed [SAMPLE_WIDTH-1:0] mac_y;
  logic                           mac_sat, mac_busy;

  // control word decode and jump
  assign ctl      = UCODE[pc];
  assign s_tready = ctl.take;
  assign accept   = s_tvalid && s_tready;
  assign push     = accept && (s_tuser == OP_FILTER);
  assign clr      = accept && (s_tuser == OP_CLEAR);
  assign out_busy = m_tvalid && !m_tready;
  assign fin_load = ctl.fin && !out_busy;
  assign ff_last  = (tap == TAP_W'(FF_TAPS - 1));
  assign fb_last  = (tap == TAP_W'(FB_DEPTH - 1));

  always_comb begin
    unique case (ctl.cond)
      JC_NEVER:    jump = 1'b0;
      JC_ALWAYS:   jump = 1'b1;
      JC_NO_START: jump = !push;
      JC_FF_MORE:  jump = !ff_last;
      JC_FB_MORE:  jump = !fb_last;
      JC_NO_FB:    jump = !HAS_FB;
      JC_OUT_BUSY: jump = out_busy;
      default:     jump = 1'b0;
    endcase
    pc_next = jump ? ctl.target : pc + PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= STEP_IDLE;
      tap <= '0;
    end else begin
      pc <= pc_next;
      if (ctl.ff_issue) begin
        tap <= ff_last ? '0 : tap + TAP_W'(1);
      end else if (ctl.fb_issue) begin
        tap <= fb_last ? '0 : tap + TAP_W'(1);
      end
    end
  end

  // circular history pointers, newest entry at the head
  assign xh_next = (xh == '0) ? FF_AW'(FF_TAPS - 1) : xh - FF_AW'(1);
  assign yh_next = (yh == '0) ? FB_AW'(FB_DEPTH - 1) : yh - FB_AW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      xh <= '0;
      yh <= '0;
    end else begin
      if (push) begin
        xh <= xh_next;
      end
      if (fin_load && HAS_FB) begin
        yh <= yh_next;
      end
    end
    if (push) begin
      xrp <= xh_next;
    end else if (ctl.ff_issue) begin
      xrp <= (xrp == FF_AW'(FF_TAPS - 1)) ? '0 : xrp + FF_AW'(1);
    end
    if (ctl.fb_issue) begin
      yrp <= (yrp == FB_AW'(FB_DEPTH - 1)) ? '0 : yrp + FB_AW'(1);
    end else begin
      yrp <= yh;
    end
  end

  // history valid bits: unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      x_valid <= '0;
      y_valid <= '0;
    end else begin
      if (push) begin
        x_valid[xh_next] <= 1'b1;
      end
      if (fin_load && HAS_FB) begin
        y_valid[yh_next] <= 1'b1;
      end
    end
  end

  // history memories
  always_ff @(posedge clk) begin
    if (push) begin
      x_mem[xh_next] <= s_tdata[SAMPLE_WIDTH-1:0];
    end
    x_rd <= x_valid[xrp] ? x_mem[xrp] : '0;
  end

  always_ff @(posedge clk) begin
    if (fin_load && HAS_FB) begin
      y_mem[yh_next] <= mac_y;
    end
    y_rd <= y_valid[yrp] ? y_mem[yrp] : '0;
  end

  // gain memories; an unwritten entry reads its reset value
  assign fb_cidx  = cfg_index - CFG_IW'(FF_TAPS);
  assign ff_gaddr = tap[FF_AW-1:0];
  assign fb_gaddr = tap[FB_AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ff_gv <= '0;
      fb_gv <= '0;
    end else if (cfg_we) begin
      if (cfg_index < CFG_IW'(FF_TAPS)) begin
        ff_gv[cfg_index[FF_AW-1:0]] <= 1'b1;
      end else if (HAS_FB && (cfg_index < CFG_IW'(FF_TAPS + FB_TAPS))) begin
        fb_gv[fb_cidx[FB_AW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_we && (cfg_index < CFG_IW'(FF_TAPS))) begin
      ff_mem[cfg_index[FF_AW-1:0]] <= cfg_data;
    end
    if (ff_gv[ff_gaddr]) begin
      ffg_rd <= ff_mem[ff_gaddr];
    end else begin
      ffg_rd <= (ff_gaddr == '0) ? GAIN_ONE : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_we && HAS_FB && (cfg_index >= CFG_IW'(FF_TAPS))
        && (cfg_index < CFG_IW'(FF_TAPS + FB_TAPS))) begin
      fb_mem[fb_cidx[FB_AW-1:0]] <= cfg_data;
    end
    fbg_rd <= fb_gv[fb_gaddr] ? fb_mem[fb_gaddr] : '0;
  end

  // read stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ctl <= '0;
    end else begin
      rd_ctl.vld <= ctl.ff_issue || ctl.fb_issue;
      rd_ctl.sub <= ctl.fb_issue;
    end
  end

  assign mac_smp  = rd_ctl.sub ? y_rd : x_rd;
  assign mac_gain = rd_ctl.sub ? fbg_rd : ffg_rd;

  dfiir_mac #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .ACC_W        (ACC_W)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .clear_acc (push),
    .iss       (rd_ctl),
    .smp       (mac_smp),
    .gain      (mac_gain),
    .y         (mac_y),
    .sat       (mac_sat),
    .busy      (mac_busy)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fin_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (fin_load) begin
      m_tdata <= OUT_W'({mac_sat, mac_y});
    end
  end

  // pipeline is empty whenever a new word may enter
  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !rd_ctl.vld && !mac_busy)
    else $error("multiply pipeline busy while accepting input");

  // the accumulator is complete when the result is taken
  a_fin_drained: assert property (@(posedge clk) disable iff (rst)
    ctl.fin |-> !rd_ctl.vld && !mac_busy)
    else $error("result taken before accumulation finished");

  // every tap walk starts from tap zero
  a_tap_start: assert property (@(posedge clk) disable iff (rst)
    push |=> tap == '0)
    else $error("tap counter not at zero at item start");

endmodule

FILE: hdl/dfiir_mac.sv
// ----------------------------------------------------------------------------
// dfiir_mac
// Shared multiply-accumulate unit: registered product, exact accumulator,
// round-to-nearest, shift by the gain fraction and saturation.
// ----------------------------------------------------------------------------
module dfiir_mac #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int ACC_W        = 42
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           clear_acc,
  input  dfiir_pkg::mac_ctl_t            iss,
  input  logic signed [SAMPLE_WIDTH-1:0] smp,
  input  logic signed [dfiir_pkg::GAIN_W-1:0] gain,
  output logic signed [SAMPLE_WIDTH-1:0] y,
  output logic                           sat,
  output logic                           busy
);
  import dfiir_pkg::*;

  localparam int PROD_W = SAMPLE_WIDTH + GAIN_W;
  localparam logic signed [ACC_W-1:0] MAXV = ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [ACC_W-1:0] MINV = -MAXV - ACC_W'(1);
  localparam logic signed [ACC_W:0]   HALF = (ACC_W+1)'(64'sd1 <<< (FRAC_BITS - 1));

  logic signed [PROD_W-1:0] prod;
  mac_ctl_t                 p_ctl;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W:0]    rnd;
  logic signed [ACC_W-1:0]  shifted;

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p_ctl <= '0;
    end else begin
      p_ctl <= iss;
    end
    prod <= smp * gain;
  end

  // accumulate, feedback terms subtracted
  always_ff @(posedge clk) begin
    if (clear_acc) begin
      acc <= '0;
    end else if (p_ctl.vld) begin
      if (p_ctl.sub) begin
        acc <= acc - ACC_W'(prod);
      end else begin
        acc <= acc + ACC_W'(prod);
      end
    end
  end

  // round half up, drop the fraction, clip
  always_comb begin
    rnd     = (ACC_W+1)'(acc) + HALF;
    shifted = ACC_W'(rnd >>> FRAC_BITS);
    sat     = 1'b0;
    y       = shifted[SAMPLE_WIDTH-1:0];
    if (shifted > MAXV) begin
      y   = MAXV[SAMPLE_WIDTH-1:0];
      sat = 1'b1;
    end else if (shifted < MINV) begin
      y   = MINV[SAMPLE_WIDTH-1:0];
      sat = 1'b1;
    end
  end

  assign busy = p_ctl.vld;

endmodule

FILE: test/direct_form_iir_filter_core_tb.sv
// ----------------------------------------------------------------------------
// direct_form_iir_filter_core_tb
// Self-checking bench for the direct-form I filter core. A directed table
// covers the sample and gain extremes, clipping, the round-half-up rule and
// the clear word. Random words then run under several gain mixes, with
// random input gaps and output stalls. Each output word is checked against
// the table's value, else a bit-exact fixed-point filter model in the bench.
// ----------------------------------------------------------------------------
module direct_form_iir_filter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dfiir_pkg::*;

  localparam int FF_TAPS      = 5;
  localparam int FB_TAPS      = 3;
  localparam int SAMPLE_WIDTH = 16;
  localparam int IDX_W        = $clog2(FF_TAPS + FB_TAPS + 1);

  // Register map: feed-forward gains first, then feedback gains
  localparam logic [IDX_W-1:0] IDX_FF0     = 4'd0;
  localparam logic [IDX_W-1:0] IDX_FF1     = 4'd1;
  localparam logic [IDX_W-1:0] IDX_FF2     = 4'd2;
  localparam logic [IDX_W-1:0] IDX_FF3     = 4'd3;
  localparam logic [IDX_W-1:0] IDX_FF4     = 4'd4;
  localparam logic [IDX_W-1:0] IDX_FB0     = 4'd5;
  localparam logic [IDX_W-1:0] IDX_FB1     = 4'd6;
  localparam logic [IDX_W-1:0] IDX_FB2     = 4'd7;
  localparam logic [IDX_W-1:0] IDX_UNUSED  = 4'd8;   // first index with no register
  localparam logic [IDX_W-1:0] IDX_TOP     = 4'd15;

  localparam logic signed [GAIN_W-1:0] GAIN_MAX     = 18'h1FFFF;
  localparam logic signed [GAIN_W-1:0] GAIN_MIN     = 18'h20000;
  localparam logic signed [GAIN_W-1:0] GAIN_HALF    = 18'h08000;
  localparam logic signed [GAIN_W-1:0] GAIN_NEG_ONE = 18'h30000;
  localparam logic signed [GAIN_W-1:0] GAIN_ZERO    = 18'h00000;

  localparam int DRAIN_CYCLES = 24;    // longer than one item takes in the core
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int STUCK_LIMIT  = 2000;  // cycles with no transfer at all
  localparam int PHASES       = 9;
  localparam int PHASE_WORDS  = 205;

  typedef enum int {
    GAINS_MILD, GAINS_ANY, GAINS_EDGE, GAINS_FIR, GAINS_PASS, GAINS_ACCUM
  } gain_mix_t;

  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] y;
    logic                    sat;
  } filtered_t;

  // One row of the directed table: either a gain write or a stream word
  typedef struct {
    bit                      is_cfg;
    logic [IDX_W-1:0]        idx;
    logic [GAIN_W-1:0]       gain;
    logic                    op;
    logic [SAMPLE_WIDTH-1:0] smp;
    bit                      typed;
    logic [SAMPLE_WIDTH-1:0] y;
    logic                    sat;
  } dir_row_t;

  localparam int N_DIR = 35;

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    s_tvalid  = 1'b0;
  logic                    s_tready;
  logic [15:0]             s_tdata   = '0;   // [15:0] sample
  logic                    s_tuser   = OP_FILTER;  // op
  logic                    m_tvalid;
  logic                    m_tready  = 1'b0;
  logic [23:0]             m_tdata;          // [15:0] filtered, [16] saturated
  logic                    cfg_we    = 1'b0;
  logic [IDX_W-1:0]        cfg_index = '0;
  logic [GAIN_W-1:0]       cfg_data  = '0;

  // Typed expectation riding along with the word on the stream
  bit                      row_typed = 1'b0;
  logic [SAMPLE_WIDTH-1:0] row_y     = '0;
  logic                    row_sat   = 1'b0;

  // Filter state kept by the bench
  logic signed [GAIN_W-1:0]       ff_gain [FF_TAPS] = '{GAIN_ONE, 0, 0, 0, 0};
  logic signed [GAIN_W-1:0]       fb_gain [FB_TAPS] = '{0, 0, 0};
  logic signed [SAMPLE_WIDTH-1:0] x_hist  [FF_TAPS] = '{0, 0, 0, 0, 0};
  logic signed [SAMPLE_WIDTH-1:0] y_hist  [FB_TAPS] = '{0, 0, 0};

  filtered_t filtered_q [$];
  int        mismatches   = 0;
  int        stuck_cycles = 0;
  int        send_idle    = 0;
  int        recv_idle    = 0;
  int        hold_left    = 0;
  bit        hold_req     = 1'b0;

  dir_row_t dir_rows [N_DIR] = '{
    // unity gain after reset: output equals input
    '{1'b0, IDX_FF0, GAIN_ZERO, OP_FILTER, 16'h7FFF, 1'b1, 16'h7FFF, 1'b0},
    '{1'b0, IDX_FF0, GAIN_ZERO, OP_FILTER, 16'h8000, 1'b1, 16'h8000, 1'b0},
    '{1'b0, IDX_FF0, GAIN_ZERO, OP_FILTER, 16'h0000, 1'b1, 16'h0000, 1'b0},
    '{1'b0, IDX_FF0, GAIN_ZERO, OP_FILTER, 16'h0001, 1'b1, 16'h0001, 1'b0},
    '{1'b0, IDX_FF0, GAIN_ZERO, OP_FILTER, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0},
    '{1'b0, IDX_FF0, GAIN_ZERO, OP_CLEAR,  16'h5A5A, 1'b0, 16'h0000, 1'b0},
    // largest positive gain: full-scale inputs clip
    '{1'b1, IDX_FF0, GAIN_MAX,  OP_FILTER, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b0, IDX_FF0, GAIN_ZERO, OP_FILTER, 16'h7FFF, 1'b1, 16'h7FFF, 1'b1},
    '{1'b0, IDX_FF0, GAIN_ZERO, OP_FILTER, 16'h8000, 1'b1, 16'h8000, 1'b1},
    '{1'b0, IDX_FF0, GAIN_ZERO, OP_FILTER, 16'h0000, 1'b1, 16'h0000, 1'b0},
    // most negative gain flips the clip direction
    '{1'b1, IDX_FF0, GAIN_MIN,  OP_FILTER, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b0, IDX_FF0, GAIN_ZERO, OP_FILTER, 16'h8000, 1'b1, 16'h7FFF, 1'b1},
    '{1'b0, IDX_FF0, GAIN_ZERO, OP_FILTER, 16'h7FFF, 1'b1, 16'h8000, 1'b1},
    // gain of one half: exact halves round up
    '{1'b1, IDX_FF0, GAIN_HALF, OP_FILTER, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b0, IDX_FF0, GAIN_ZERO, OP_FILTER, 16'h0001, 1'b1, 16'h0001, 1'b0},
    '{1'b0, IDX_FF0, GAIN_ZERO, OP_FILTER, 16'hFFFF, 1'b1, 16'h0000, 1'b0},
    '{1'b0, IDX_FF0, GAIN_ZERO, OP_FILTER, 16'h0003, 1'b1, 16'h0002, 1'b0},
    '{1'b0, IDX_FF0, GAIN_ZERO, OP_FILTER, 16'hFFFD, 1'b1, 16'hFFFF, 1'b0},
    // all taps live, feedback included
    '{1'b1, IDX_FF1, GAIN_MAX,     OP_FILTER, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b1, IDX_FF2, GAIN_MIN,     OP_FILTER, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b1, IDX_FF3, 18'h03039,    OP_FILTER, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b1, IDX_FF4, 18'h3FFF9,    OP_FILTER, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b1, IDX_FB0, GAIN_NEG_ONE, OP_FILTER, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b1, IDX_FB1, GAIN_MAX,     OP_FILTER, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b1, IDX_FB2, GAIN_MIN,     OP_FILTER, 16'h0000, 1'b0, 16'h0000, 1'b0},
    // writes to indexes with no register are dropped
    '{1'b1, IDX_UNUSED, 18'h3FFFF, OP_FILTER, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b1, IDX_TOP,    18'h15555, OP_FILTER, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b0, IDX_FF0, GAIN_ZERO, OP_FILTER, 16'h03E8, 1'b0, 16'h0000, 1'b0},
    '{1'b0, IDX_FF0, GAIN_ZERO, OP_FILTER, 16'hF830, 1'b0, 16'h0000, 1'b0},
    '{1'b0, IDX_FF0, GAIN_ZERO, OP_FILTER, 16'h7FFF, 1'b0, 16'h0000, 1'b0},
    '{1'b0, IDX_FF0, GAIN_ZERO, OP_FILTER, 16'h8000, 1'b0, 16'h0000, 1'b0},
    '{1'b0, IDX_FF0, GAIN_ZERO, OP_FILTER, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b0, IDX_FF0, GAIN_ZERO, OP_FILTER, 16'h0007, 1'b0, 16'h0000, 1'b0},
    '{1'b0, IDX_FF0, GAIN_ZERO, OP_CLEAR,  16'hFFFF, 1'b0, 16'h0000, 1'b0},
    '{1'b0, IDX_FF0, GAIN_ZERO, OP_FILTER, 16'h01F4, 1'b0, 16'h0000, 1'b0}
  };

  direct_form_iir_filter_core #(
    .FF_TAPS      (FF_TAPS),
    .FB_TAPS      (FB_TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Push one sample through the filter and return the rounded, clipped output
  function automatic void filter_sample(input logic signed [SAMPLE_WIDTH-1:0] smp,
                                        output logic [SAMPLE_WIDTH-1:0] y_out,
                                        output logic sat);
    longint acc;
    longint y;
    acc = 0;
    sat = 1'b0;
    for (int i = FF_TAPS - 1; i > 0; i--) x_hist[i] = x_hist[i-1];
    x_hist[0] = smp;
    for (int i = 0; i < FF_TAPS; i++) acc += longint'(x_hist[i]) * longint'(ff_gain[i]);
    for (int i = 0; i < FB_TAPS; i++) acc -= longint'(y_hist[i]) * longint'(fb_gain[i]);
    // add one half, then floor
    y = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (y > 32767) begin
      y = 32767;
      sat = 1'b1;
    end else if (y < -32768) begin
      y = -32768;
      sat = 1'b1;
    end
    for (int i = FB_TAPS - 1; i > 0; i--) y_hist[i] = y_hist[i-1];
    y_hist[0] = y[SAMPLE_WIDTH-1:0];
    y_out = y[SAMPLE_WIDTH-1:0];
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain(input gain_mix_t mix, input int tap);
    int v;
    logic [GAIN_W-1:0] edges [6];
    edges = '{GAIN_MAX, GAIN_MIN, GAIN_ZERO, GAIN_ONE, GAIN_NEG_ONE, GAIN_HALF};
    case (mix)
      GAINS_MILD: begin
        if (tap < FF_TAPS) v = int'($urandom_range(32767)) - 16384;
        else v = int'($urandom_range(16383)) - 8192;
        return v[GAIN_W-1:0];
      end
      GAINS_ANY:  return GAIN_W'($urandom);
      GAINS_EDGE: return edges[$urandom_range(5)];
      GAINS_FIR:  return (tap < FF_TAPS) ? GAIN_W'($urandom) : GAIN_ZERO;
      GAINS_PASS: return (tap == 0) ? GAIN_ONE : GAIN_ZERO;
      default: begin
        // running sum: feedback of minus one adds the previous output back in
        if (tap == IDX_FB0) return GAIN_NEG_ONE;
        v = int'($urandom_range(4095)) - 2048;
        return v[GAIN_W-1:0];
      end
    endcase
  endfunction

  function automatic logic [SAMPLE_WIDTH-1:0] rand_sample();
    int r;
    int v;
    logic [SAMPLE_WIDTH-1:0] edges [5];
    edges = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001};
    r = $urandom_range(99);
    if (r < 30) return SAMPLE_WIDTH'($urandom);
    if (r < 40) return edges[$urandom_range(4)];
    v = int'($urandom_range(4000)) - 2000;
    return v[SAMPLE_WIDTH-1:0];
  endfunction

  // Offer one word, with random gaps before it, and wait until it is taken
  task automatic send_word(input logic op, input logic [SAMPLE_WIDTH-1:0] smp,
                           input bit typed, input logic [SAMPLE_WIDTH-1:0] y,
                           input logic sat);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid  <= 1'b1;
    s_tuser   <= op;
    s_tdata   <= smp;
    row_typed <= typed;
    row_y     <= y;
    row_sat   <= sat;
    do @(posedge clk); while (!(s_tvalid && s_tready));
  endtask

  // Stop sending, wait for every pending output and let the core go quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Caller lowers cfg_we after the last write of a batch
  task automatic write_gain(input logic [IDX_W-1:0] idx, input logic [GAIN_W-1:0] g);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= g;
    @(posedge clk);
    if (idx < FF_TAPS) ff_gain[idx] = g;
    else if (idx < FF_TAPS + FB_TAPS) fb_gain[idx - FF_TAPS] = g;
  endtask

  // Input side: advance the model on every accepted word
  always @(posedge clk) begin : take_mon
    logic [SAMPLE_WIDTH-1:0] y;
    logic                    sat;
    if (!rst && s_tvalid && s_tready) begin
      if (s_tuser == OP_CLEAR) begin
        foreach (x_hist[i]) x_hist[i] = '0;
        foreach (y_hist[i]) y_hist[i] = '0;
      end else begin
        filter_sample(s_tdata, y, sat);
        if (row_typed) begin
          y   = row_y;
          sat = row_sat;
        end
        filtered_q.push_back('{y, sat});
      end
    end
  end

  // Output side: compare each word with the oldest pending one
  always @(posedge clk) begin : out_mon
    filtered_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (filtered_q.size() == 0) begin
        $display("%0t: output word %h with nothing pending", $time, m_tdata);
        mismatches++;
      end else begin
        want = filtered_q.pop_front();
        if (m_tdata[15:0] !== want.y) begin
          $display("%0t: filtered expected %h got %h", $time, want.y, m_tdata[15:0]);
          mismatches++;
        end
        if (m_tdata[16] !== want.sat) begin
          $display("%0t: saturated expected %b got %b", $time, want.sat, m_tdata[16]);
          mismatches++;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog on cycles with no transfer of any kind
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("direct_form_iir_filter_core_tb failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : stimulus
    logic op;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_idle = 27;
    recv_idle = 63;

    // directed table
    foreach (dir_rows[r]) begin
      if (dir_rows[r].is_cfg) begin
        settle();
        write_gain(dir_rows[r].idx, dir_rows[r].gain);
        cfg_we <= 1'b0;
      end else begin
        send_word(dir_rows[r].op, dir_rows[r].smp, dir_rows[r].typed,
                  dir_rows[r].y, dir_rows[r].sat);
      end
    end

    // random phases, each under a fresh gain mix
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      if (ph < 3) begin
        send_idle = 27;
        recv_idle = 63;
      end else if (ph < 6) begin
        send_idle = 63;
        recv_idle = 27;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      for (int i = 0; i < FF_TAPS + FB_TAPS; i++)
        write_gain(IDX_W'(i), pick_gain(gain_mix_t'(ph % 6), i));
      write_gain(IDX_UNUSED + IDX_W'($urandom_range(7)), GAIN_W'($urandom));
      cfg_we <= 1'b0;
      if (ph == 1 || ph == 4) hold_req = 1'b1;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // sender pause until the core has delivered everything
        if (n == PHASE_WORDS / 2) settle();
        op = ($urandom_range(99) < 4) ? OP_CLEAR : OP_FILTER;
        send_word(op, rand_sample(), 1'b0, '0, 1'b0);
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("direct_form_iir_filter_core_tb passed");
    end else begin
      $display("direct_form_iir_filter_core_tb failed");
    end
    $finish;
  end

endmodule
